[hdl/ics_pkg.sv]
// shared types and constants for the internet checksum stream unit
`timescale 1ns / 1ps

package ics_pkg;

  // byte lanes that the input word actually carries
  localparam int unsigned LANES_MAX = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;

  typedef logic [WORD_W-1:0] word_t;

  // control from the lane stage into the merge stage
  typedef struct packed {
    logic adv;   // lane stage hands its item to the merge stage
    logic last;  // that item closes the packet
  } merge_ctrl_t;

endpackage

[hdl/ics_lane.sv]
// one byte lane: places an enabled byte at its low or high position by stream parity
`timescale 1ns / 1ps

module ics_lane
  import ics_pkg::*;
#(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic [BYTE_W-1:0]    byte_i,
  input  logic [LANES_MAX-1:0] enable_i,
  input  logic                 odd_i,
  output word_t                word_o
);

  localparam logic [LANES_MAX-1:0] LowerMask =
    LANES_MAX'((1 << LANE_IDX) - 1);

  logic odd_pos;

  // parity of this byte: running parity plus enabled bytes ahead of it
  assign odd_pos = odd_i ^ (^(enable_i & LowerMask));

  // disabled bytes contribute nothing
  always_comb begin
    if (!enable_i[LANE_IDX]) begin
      word_o = '0;
    end else if (odd_pos) begin
      word_o = {byte_i, {BYTE_W{1'b0}}};
    end else begin
      word_o = {{BYTE_W{1'b0}}, byte_i};
    end
  end

endmodule

[hdl/ics_merge.sv]
// merge stage: sums lane words into the running ones' complement sum
`timescale 1ns / 1ps

module ics_merge
  import ics_pkg::*;
#(
  parameter int unsigned NUM_LANES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  merge_ctrl_t                ctrl_i,
  input  logic [NUM_LANES-1:0][WORD_W-1:0] words_i,
  output word_t                      checksum_o,
  output word_t                      folded_sum_o
);

  localparam int unsigned SumW = WORD_W + $clog2(NUM_LANES + 1);

  word_t             acc_q, acc_d;
  word_t             checksum_q, folded_q;
  logic [SumW-1:0]   total;
  logic [WORD_W:0]   fold1;
  word_t             folded;

  // plain binary sum of lanes and accumulator, folded afterwards
  always_comb begin
    total = SumW'(acc_q);
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      total = total + SumW'(words_i[i]);
    end
  end

  // end-around carry: fold the high bits in, then one more carry
  assign fold1  = {1'b0, total[WORD_W-1:0]} + (WORD_W+1)'(total[SumW-1:WORD_W]);
  assign folded = fold1[WORD_W] ? (fold1[WORD_W-1:0] + word_t'(1)) : fold1[WORD_W-1:0];

  // accumulator clears once a packet closes
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.adv) begin
      acc_d = ctrl_i.last ? '0 : folded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // result register, loaded on the closing item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv && ctrl_i.last) begin
      folded_q   <= folded;
      checksum_q <= ~folded;
    end
  end

  assign checksum_o   = checksum_q;
  assign folded_sum_o = folded_q;

endmodule

[hdl/internet_checksum_stream_unit.sv]
// top level of the streaming internet checksum unit
`timescale 1ns / 1ps

// Streaming 16-bit Internet ones' complement checksum. Each transfer on the
// input channel carries up to four bytes with a byte-enable mask; enabled
// bytes pair up little-endian by running stream parity, and skipped bytes
// neither count nor shift the parity. The transfer marked last produces one
// result transfer with the complemented checksum and the folded raw sum, and
// the unit then starts a fresh packet. One input transfer is taken every
// cycle while the result side keeps up; a closing item waits in the lane
// register while an earlier result is still unaccepted, and the input stalls
// behind it. The result is offered from the result register: the lane
// register loads on the accepting edge of the last transfer, and the result
// register loads once the closing item advances. Sustained rate is set by
// the accumulate-and-fold in the merge stage. An empty packet gives
// folded_sum 0 and checksum 0xffff.
module internet_checksum_stream_unit
  import ics_pkg::*;
#(
  parameter int unsigned BYTES_PER_ITEM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [3:0]  byte_enable_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] checksum_o,
  output logic [15:0] folded_sum_o
);

  localparam int unsigned ActiveLanes =
    (BYTES_PER_ITEM < LANES_MAX) ? BYTES_PER_ITEM : LANES_MAX;
  localparam logic [LANES_MAX-1:0] ActiveMask =
    LANES_MAX'((1 << ActiveLanes) - 1);

  logic                                    in_xfer;
  logic                                    out_free;
  logic                                    s1_adv;
  logic [LANES_MAX-1:0]                    en_eff;
  logic [BYTES_PER_ITEM-1:0][WORD_W-1:0]   lane_word;
  logic [BYTES_PER_ITEM-1:0][WORD_W-1:0]   s1_word_q;
  logic                                    s1_valid_q, s1_valid_d;
  logic                                    s1_last_q;
  logic                                    odd_q, odd_d;
  logic                                    out_valid_q, out_valid_d;
  merge_ctrl_t                             merge_ctrl;

  // lanes beyond the input word stay disabled
  assign en_eff = byte_enable_i & ActiveMask;

  // byte lanes
  for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
    if (g < LANES_MAX) begin : g_real
      ics_lane #(
        .LANE_IDX (g)
      ) u_lane (
        .byte_i   (data_word_i[BYTE_W*g +: BYTE_W]),
        .enable_i (en_eff),
        .odd_i    (odd_q),
        .word_o   (lane_word[g])
      );
    end else begin : g_none
      assign lane_word[g] = '0;
    end
  end

  // handshake: a closing item needs the result register free
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // next state of the lane stage, parity and result valid
  always_comb begin
    s1_valid_d  = s1_valid_q;
    odd_d       = odd_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_d = 1'b1;
      odd_d      = last_i ? 1'b0 : (odd_q ^ (^en_eff));
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      odd_q       <= odd_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        s1_last_q <= last_i;
      end
    end
  end

  // lane word register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q <= lane_word;
    end
  end

  assign merge_ctrl.adv  = s1_adv;
  assign merge_ctrl.last = s1_last_q;

  ics_merge #(
    .NUM_LANES (BYTES_PER_ITEM)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (merge_ctrl),
    .words_i      (s1_word_q),
    .checksum_o   (checksum_o),
    .folded_sum_o (folded_sum_o)
  );

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // stalled input only when the lane stage holds an item
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with empty lane stage");

  // a closing transfer restarts parity at an even position
  a_parity_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_i |=> !odd_q)
    else $error("parity not cleared after last transfer");

  // a closing item never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |-> out_free)
    else $error("result register overwritten");

  // merging a closing item raises a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> out_valid_o)
    else $error("no result after closing item");

  // the two result fields stay complementary
  a_fields_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (checksum_o == ~folded_sum_o))
    else $error("checksum and folded sum disagree");
`endif

endmodule

[tb/ics_checker.sv]
// transfer monitor, checksum predictor and result comparison for the checksum unit
`timescale 1ns / 1ps

module ics_checker
  import ics_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] data_word_i,
  input  logic [3:0]  byte_enable_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] checksum_i,
  input  logic [15:0] folded_sum_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    word_t checksum;
    word_t folded_sum;
  } packet_sum_t;

  // checksums of closed packets whose result transfer has not come yet
  packet_sum_t expected_sums[$];

  // predicted packet state
  word_t run_sum;
  logic  odd_pos;

  // ones' complement add with end-around carry
  function automatic word_t add_end_around(word_t acc, word_t val);
    logic [WORD_W:0] s;
    s = {1'b0, acc} + {1'b0, val};
    if (s > {1'b0, {WORD_W{1'b1}}}) s = s - {1'b0, {WORD_W{1'b1}}};
    return s[WORD_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    packet_sum_t want;
    logic [BYTE_W-1:0] lane_byte;
    if (!rst_ni) begin
      run_sum = '0;
      odd_pos = 1'b0;
      expected_sums.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // result side first, so a stray result never meets an expectation pushed this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_sums.size() == 0) begin
          $error("result transfer with nothing expected: checksum %h folded_sum %h",
                 checksum_i, folded_sum_i);
          fail_count_o++;
        end else begin
          want = expected_sums.pop_front();
          if (checksum_i !== want.checksum) begin
            $error("checksum mismatch: expected %h, actual %h", want.checksum, checksum_i);
            fail_count_o++;
          end
          if (folded_sum_i !== want.folded_sum) begin
            $error("folded_sum mismatch: expected %h, actual %h",
                   want.folded_sum, folded_sum_i);
            fail_count_o++;
          end
        end
      end
      // fold enabled bytes in stream order, pairing by running parity
      if (in_valid_i && in_ready_i) begin
        for (int unsigned lane = 0; lane < LANES_MAX; lane++) begin
          if (byte_enable_i[lane]) begin
            lane_byte = data_word_i[BYTE_W*lane +: BYTE_W];
            run_sum = add_end_around(run_sum, odd_pos ? {lane_byte, 8'h00} : {8'h00, lane_byte});
            odd_pos = ~odd_pos;
          end
        end
        if (last_i) begin
          want.checksum = ~run_sum;
          want.folded_sum = run_sum;
          expected_sums.push_back(want);
          run_sum = '0;
          odd_pos = 1'b0;
        end
      end
      pending_o = expected_sums.size();
    end
  end

endmodule

[tb/tb.sv]
// testbench top: stimulus, flow control and verdict for the checksum unit
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [3:0]  byte_enable = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] checksum;
  logic [15:0] folded_sum;

  int fail_count;
  int pending;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  internet_checksum_stream_unit #(
    .BYTES_PER_ITEM(4)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_word_i  (data_word),
    .byte_enable_i(byte_enable),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .checksum_o   (checksum),
    .folded_sum_o (folded_sum)
  );

  ics_checker u_sum_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_word_i  (data_word),
    .byte_enable_i(byte_enable),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .checksum_i   (checksum),
    .folded_sum_i (folded_sum),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side flow control, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // offer one word, with random idle cycles first, and wait for its transfer
  task automatic send_word(input logic [31:0] d, input logic [3:0] be, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      data_word = $urandom();
      byte_enable = 4'($urandom_range(0, 15));
      last = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_valid = 1'b1;
    data_word = d;
    byte_enable = be;
    last = l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every closed packet has its result
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // one packet of random length; masks mostly full, some partial, some empty
  task automatic send_random_packet();
    int n;
    int sel;
    logic [31:0] d;
    logic [3:0] be;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      d = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hffff_ffff : $urandom();
      sel = $urandom_range(0, 9);
      if (sel <= 5) be = 4'hf;
      else if (sel <= 8) be = 4'($urandom_range(0, 15));
      else be = 4'h0;
      // skipped prefix at the start of the packet
      if (k == 0 && $urandom_range(0, 3) == 0) be = 4'hf << $urandom_range(1, 3);
      send_word(d, be, k == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty packet, extremes, odd counts, parity across words
    send_word(32'h0000_0000, 4'h0, 1'b1);
    send_word(32'hffff_ffff, 4'hf, 1'b1);
    send_word(32'h0000_0000, 4'hf, 1'b1);
    send_word(32'hffff_ffff, 4'h0, 1'b1);
    send_word(32'h00ff_00ff, 4'hf, 1'b1);
    send_word(32'h0012_3456, 4'h7, 1'b1);
    send_word(32'h0000_00ab, 4'h1, 1'b0);
    send_word(32'hdead_beef, 4'hf, 1'b1);
    send_word(32'h1122_3344, 4'hc, 1'b0);
    send_word(32'h5566_7788, 4'h0, 1'b0);
    send_word(32'h99aa_bbcc, 4'hf, 1'b0);
    send_word(32'hddee_ff01, 4'h3, 1'b1);
    send_word(32'h03f2_0100, 4'hf, 1'b0);
    send_word(32'hf7f6_f5f4, 4'hf, 1'b1);
    send_word(32'hffff_0001, 4'hf, 1'b0);
    send_word(32'hffff_ffff, 4'hf, 1'b1);
    send_word(32'h8080_8080, 4'ha, 1'b0);
    send_word(32'h8080_8080, 4'h5, 1'b1);
    send_word(32'h0000_0000, 4'hf, 1'b0);
    send_word(32'h0000_0000, 4'h0, 1'b1);
    send_word(32'hffff_ffff, 4'h8, 1'b1);
    wait_drained();

    // receiver holds off while single-word packets keep coming
    hold_seq++;
    repeat (48) send_word($urandom(), 4'hf, 1'b1);
    wait_drained();

    // random packets under each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      while (items_sent < 70 + 255 * (phase + 1)) send_random_packet();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/ics_pkg.sv
hdl/ics_lane.sv
hdl/ics_merge.sv
hdl/internet_checksum_stream_unit.sv
tb/ics_checker.sv
tb/tb.sv
